// ----- hdl/box_muller_normal_sampler_core_macros.svh -----
// Assertion helpers for the Gaussian sampler.
`ifndef BOX_MULLER_NORMAL_SAMPLER_CORE_MACROS_SVH
`define BOX_MULLER_NORMAL_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BMNS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sampler check failed");
`define BMNS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sampler check failed");
`else
`define BMNS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BMNS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/bmns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bmns_pkg;

	localparam int DEF_UNIFORM_BITS = 16;
	localparam int LOG_ITERS        = 28;
	localparam int SQRT_ITERS       = 32;
	localparam int SIN_TERMS        = 5;
	localparam int SERIES_STEPS     = 11;

	localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h40000000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_NORM,
		OP_SQR,
		OP_LQLO,
		OP_LQHI,
		OP_SQRT,
		OP_ANG,
		OP_X2,
		OP_TMUL,
		OP_TDIV,
		OP_TCOR,
		OP_PZ,
		OP_PS,
		OP_SCALE
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] step;
		logic       load;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic spare_valid;
		logic out_free;
	} dp_sts_t;

	// Factorial factor pair of each series term: sine steps first, then cosine.
	function automatic logic [7:0] series_div(input logic [3:0] idx);
		logic [7:0] d;
		unique case (idx)
			4'd0:    d = 8'd6;
			4'd1:    d = 8'd20;
			4'd2:    d = 8'd42;
			4'd3:    d = 8'd72;
			4'd4:    d = 8'd110;
			4'd5:    d = 8'd2;
			4'd6:    d = 8'd12;
			4'd7:    d = 8'd30;
			4'd8:    d = 8'd56;
			4'd9:    d = 8'd90;
			4'd10:   d = 8'd132;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor), the quotient estimate is then off by at most one
	function automatic logic [31:0] series_recip(input logic [3:0] idx);
		logic [31:0] r;
		unique case (idx)
			4'd0:    r = 32'd715827882;
			4'd1:    r = 32'd214748364;
			4'd2:    r = 32'd102261126;
			4'd3:    r = 32'd59652323;
			4'd4:    r = 32'd39045157;
			4'd5:    r = 32'd2147483648;
			4'd6:    r = 32'd357913941;
			4'd7:    r = 32'd143165576;
			4'd8:    r = 32'd76695844;
			4'd9:    r = 32'd47721858;
			4'd10:   r = 32'd32537631;
			default: r = 32'hFFFFFFFF;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bmns_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmns_ctrl import bmns_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    request_valid,
	output logic         request_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_NORM  = 14'b00000000000010,
		S_SQR   = 14'b00000000000100,
		S_LQLO  = 14'b00000000001000,
		S_LQHI  = 14'b00000000010000,
		S_SQRT  = 14'b00000000100000,
		S_ANG   = 14'b00000001000000,
		S_X2    = 14'b00000010000000,
		S_TMUL  = 14'b00000100000000,
		S_TDIV  = 14'b00001000000000,
		S_TCOR  = 14'b00010000000000,
		S_PZ    = 14'b00100000000000,
		S_PS    = 14'b01000000000000,
		S_SCALE = 14'b10000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign request_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = OP_NONE;
		cmd.step = cnt_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (request_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.spare_valid ? S_SCALE : S_NORM;
				end
			end
			S_NORM: begin
				cmd.op  = OP_NORM;
				cnt_d   = '0;
				state_d = S_SQR;
			end
			S_SQR: begin
				cmd.op = OP_SQR;
				if (cnt_q == 5'(LOG_ITERS - 1)) begin
					state_d = S_LQLO;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_LQLO: begin
				cmd.op  = OP_LQLO;
				state_d = S_LQHI;
			end
			S_LQHI: begin
				cmd.op  = OP_LQHI;
				cnt_d   = 5'(SQRT_ITERS - 1);
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == 5'd0) begin
					state_d = S_ANG;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			S_ANG: begin
				cmd.op  = OP_ANG;
				state_d = S_X2;
			end
			S_X2: begin
				cmd.op  = OP_X2;
				cnt_d   = '0;
				state_d = S_TMUL;
			end
			S_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = S_TDIV;
			end
			S_TDIV: begin
				cmd.op  = OP_TDIV;
				state_d = S_TCOR;
			end
			S_TCOR: begin
				cmd.op = OP_TCOR;
				if (cnt_q == 5'(SERIES_STEPS - 1)) begin
					state_d = S_PZ;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = S_TMUL;
				end
			end
			S_PZ: begin
				cmd.op  = OP_PZ;
				state_d = S_PS;
			end
			S_PS: begin
				cmd.op  = OP_PS;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.op = OP_SCALE;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/bmns_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmns_dp import bmns_pkg::*; #(
	parameter int UNIFORM_BITS = DEF_UNIFORM_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dp_cmd_t                 cmd,
	output dp_sts_t                      sts,
	input  wire logic signed [15:0]      mean,
	input  wire logic [13:0]             spread,
	input  wire logic [UNIFORM_BITS-1:0] uniform_radius,
	input  wire logic [UNIFORM_BITS-1:0] uniform_angle,
	input  wire logic                    sample_stall,
	output logic                         sample_valid,
	output logic signed [18:0]           sample,
	output logic                         from_spare
);

	localparam int EW = $clog2(UNIFORM_BITS);
	localparam int PHASE_SHIFT = 32 - UNIFORM_BITS;
	localparam longint unsigned ZERO_RAW = ((64'd1 << UNIFORM_BITS) + 64'd5000) / 64'd10000;
	localparam logic [UNIFORM_BITS-1:0] ZERO_SUB =
		(ZERO_RAW == 64'd0) ? UNIFORM_BITS'(1) : UNIFORM_BITS'(ZERO_RAW);

	// item registers
	logic signed [15:0]      mean_q;
	logic [13:0]             spread_q;
	logic [UNIFORM_BITS-1:0] u1_q, u2_q;
	logic                    use_spare_q;
	// cached second value
	logic                    spare_valid_q;
	logic signed [15:0]      spare_q;
	// log / sqrt
	logic [EW-1:0]           e_q;
	logic [30:0]             m_q;
	logic [27:0]             f_q;
	logic [47:0]             acc_q;
	logic [63:0]             n_q, res_q;
	// sine / cosine series
	logic [29:0]             ang_q, x2_q;
	logic [30:0]             term_q;
	logic [31:0]             tmp_q, quo_q;
	logic signed [32:0]      sin_q, cos_q;
	logic signed [15:0]      z_q;
	// result register
	logic                    valid_q;
	logic signed [18:0]      sample_q;
	logic                    from_spare_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	function automatic logic [30:0] clamp_trig(input logic signed [32:0] s);
		logic [30:0] c;
		if (s[32]) begin
			c = '0;
		end else if (s > 33'sh040000000) begin
			c = ONE_Q30;
		end else begin
			c = s[30:0];
		end
		return c;
	endfunction

	// round a Q.58 magnitude to Q.12, then apply sign and clamp to 16 bits
	function automatic logic signed [15:0] round_z(input logic [63:0] p, input logic neg);
		logic [63:0]        rs;
		logic [17:0]        zm;
		logic signed [15:0] z;
		rs = p + 64'h0000_2000_0000_0000;
		zm = rs[63:46];
		if (neg) begin
			z = (zm >= 18'd32768) ? 16'sh8000 : 16'(18'd0 - zm);
		end else begin
			z = (zm > 18'd32767) ? 16'sh7FFF : zm[15:0];
		end
		return z;
	endfunction

	// normalize
	logic [UNIFORM_BITS-1:0] x_c;
	logic [EW-1:0]           e_c;
	logic [30:0]             m_c;
	always_comb begin
		x_c = (u1_q == '0) ? ZERO_SUB : u1_q;
		e_c = '0;
		for (int i = 0; i < UNIFORM_BITS; i++) begin
			if (x_c[i]) begin
				e_c = EW'(i);
			end
		end
		m_c = 31'((64'(x_c) << 30) >> e_c);
	end

	logic [33:0] lq_c;
	assign lq_c = ((34'(UNIFORM_BITS) - 34'(e_q)) << 28) - 34'(f_q);

	logic [31:0] sq_c;
	assign sq_c = mul_p[61:30];

	logic [64:0] tsum_c;
	assign tsum_c = {mul_p[47:0], 17'd0} + 65'(acc_q);

	logic [63:0] bit_c, trial_c;
	assign bit_c   = 64'd1 << {cmd.step, 1'b0};
	assign trial_c = res_q + bit_c;

	// angle reduction into the first octant
	logic [31:0] phase_c;
	logic [1:0]  quad_c;
	logic [29:0] fr_c, g_c;
	logic        swap_c;
	assign phase_c = 32'(64'(u2_q) << PHASE_SHIFT);
	assign quad_c  = phase_c[31:30];
	assign fr_c    = phase_c[29:0];
	assign swap_c  = fr_c > 30'h20000000;
	assign g_c     = swap_c ? 30'(31'h40000000 - 31'(fr_c)) : fr_c;

	logic [3:0]  idx_c;
	logic [7:0]  div_c;
	logic [31:0] rem_c, qf_c;
	logic        sub_c;
	assign idx_c = cmd.step[3:0];
	assign div_c = series_div(idx_c);
	assign rem_c = tmp_q - 32'(quo_q * 32'(div_c));
	assign qf_c  = quo_q + 32'((rem_c >= 32'(div_c)) ? 1 : 0);
	assign sub_c = (idx_c < 4'(SIN_TERMS)) ? ~idx_c[0] : idx_c[0];

	logic [30:0] sin_c, cos_c, sa_c, ca_c, cmag_c, smag_c;
	logic        cneg_c, sneg_c;
	assign sin_c  = clamp_trig(sin_q);
	assign cos_c  = clamp_trig(cos_q);
	assign sa_c   = swap_c ? cos_c : sin_c;
	assign ca_c   = swap_c ? sin_c : cos_c;
	assign cmag_c = quad_c[0] ? sa_c : ca_c;
	assign smag_c = quad_c[0] ? ca_c : sa_c;
	assign cneg_c = quad_c[0] ^ quad_c[1];
	assign sneg_c = quad_c[1];

	// scale and offset
	logic signed [15:0] zsrc_c;
	logic               zneg_c;
	logic [16:0]        zmag_c;
	logic [32:0]        rsum_c;
	logic [22:0]        rext_c, mext_c;
	logic signed [22:0] tot_c;
	logic signed [18:0] smp_c;
	always_comb begin
		zsrc_c = use_spare_q ? spare_q : z_q;
		zneg_c = zsrc_c[15];
		zmag_c = zneg_c ? (17'd0 - {zsrc_c[15], zsrc_c}) : {1'b0, zsrc_c};
		rsum_c = 33'(mul_p[31:0]) + 33'd2048;
		rext_c = {2'b00, rsum_c[32:12]};
		mext_c = {{7{mean_q[15]}}, mean_q};
		tot_c  = signed'(zneg_c ? (mext_c - rext_c) : (mext_c + rext_c));
		if (tot_c > 23'sd262143) begin
			smp_c = 19'sd262143;
		end else if (tot_c < -23'sd262144) begin
			smp_c = -19'sd262144;
		end else begin
			smp_c = tot_c[18:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQR: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			OP_LQLO: begin
				mul_a = 32'(lq_c[16:0]);
				mul_b = 32'(TWO_LN2_Q30);
			end
			OP_LQHI: begin
				mul_a = 32'(lq_c[33:17]);
				mul_b = 32'(TWO_LN2_Q30);
			end
			OP_ANG: begin
				mul_a = 32'(g_c);
				mul_b = 32'(HALF_PI_Q30);
			end
			OP_X2: begin
				mul_a = 32'(ang_q);
				mul_b = 32'(ang_q);
			end
			OP_TMUL: begin
				mul_a = 32'(term_q);
				mul_b = 32'(x2_q);
			end
			OP_TDIV: begin
				mul_a = tmp_q;
				mul_b = series_recip(idx_c);
			end
			OP_PZ: begin
				mul_a = res_q[31:0];
				mul_b = 32'(cmag_c);
			end
			OP_PS: begin
				mul_a = res_q[31:0];
				mul_b = 32'(smag_c);
			end
			OP_SCALE: begin
				mul_a = 32'(zmag_c);
				mul_b = 32'(spread_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mean_q      <= mean;
			spread_q    <= spread;
			u1_q        <= uniform_radius;
			u2_q        <= uniform_angle;
			use_spare_q <= spare_valid_q;
		end
		if (cmd.emit) begin
			sample_q     <= smp_c;
			from_spare_q <= use_spare_q;
		end
		case (cmd.op)
			OP_NORM: begin
				e_q <= e_c;
				m_q <= m_c;
				f_q <= '0;
			end
			OP_SQR: begin
				m_q <= sq_c[31] ? sq_c[31:1] : sq_c[30:0];
				f_q <= {f_q[26:0], sq_c[31]};
			end
			OP_LQLO: acc_q <= mul_p[47:0];
			OP_LQHI: begin
				n_q   <= {2'b00, tsum_c[63:30], 28'd0};
				res_q <= '0;
			end
			OP_SQRT: begin
				if (n_q >= trial_c) begin
					n_q   <= n_q - trial_c;
					res_q <= (res_q >> 1) + bit_c;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			OP_ANG: ang_q <= mul_p[59:30];
			OP_X2: begin
				x2_q   <= mul_p[59:30];
				term_q <= {1'b0, ang_q};
				sin_q  <= 33'(ang_q);
				cos_q  <= 33'(ONE_Q30);
			end
			OP_TMUL: tmp_q <= mul_p[61:30];
			OP_TDIV: quo_q <= mul_p[63:32];
			OP_TCOR: begin
				// cosine series restarts from one after the last sine term
				term_q <= (idx_c == 4'(SIN_TERMS - 1)) ? ONE_Q30 : qf_c[30:0];
				if (idx_c < 4'(SIN_TERMS)) begin
					sin_q <= sub_c ? (sin_q - signed'(33'(qf_c))) : (sin_q + signed'(33'(qf_c)));
				end else begin
					cos_q <= sub_c ? (cos_q - signed'(33'(qf_c))) : (cos_q + signed'(33'(qf_c)));
				end
			end
			OP_PZ: z_q <= round_z(mul_p, cneg_c);
			OP_PS: spare_q <= round_z(mul_p, sneg_c);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (!sample_stall) begin
				valid_q <= 1'b0;
			end
			if (cmd.load) begin
				spare_valid_q <= 1'b0;
			end else if (cmd.op == OP_PS) begin
				spare_valid_q <= 1'b1;
			end
		end
	end

	assign sts.spare_valid = spare_valid_q;
	assign sts.out_free    = !valid_q || !sample_stall;
	assign sample_valid    = valid_q;
	assign sample          = sample_q;
	assign from_spare      = from_spare_q;

endmodule
`default_nettype wire

// ----- hdl/box_muller_normal_sampler_core.sv -----
// channel   | signals                                             | dir
// request   | request_valid request_stall mean spread             | in
//           | uniform_radius uniform_angle                        |
// sample    | sample_valid sample_stall sample from_spare         | out
//
// A request that finds a cached spare value goes straight to the scale step.
// A request that starts a new pair runs 28 squaring steps for log2, 32 steps
// of the bit-serial square root and 11 series terms for sine and cosine,
// all on one shared 32x32 multiplier.
// Reset clears the spare flag and the output valid flag; no clearing pass.
// A stalled result stays in the output register; the next request is taken
// meanwhile and its work waits only at the final write of the result.
`timescale 1ns / 1ps
`default_nettype none
`include "box_muller_normal_sampler_core_macros.svh"
module box_muller_normal_sampler_core import bmns_pkg::*; #(
	parameter int UNIFORM_BITS = DEF_UNIFORM_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    request_valid,
	output logic                         request_stall,
	input  wire logic signed [15:0]      mean,
	input  wire logic [13:0]             spread,
	input  wire logic [UNIFORM_BITS-1:0] uniform_radius,
	input  wire logic [UNIFORM_BITS-1:0] uniform_angle,
	output logic                         sample_valid,
	input  wire logic                    sample_stall,
	output logic signed [18:0]           sample,
	output logic                         from_spare
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    req_xfer;

	assign req_xfer = request_valid && !request_stall;

	bmns_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	bmns_dp #(
		.UNIFORM_BITS (UNIFORM_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mean           (mean),
		.spread         (spread),
		.uniform_radius (uniform_radius),
		.uniform_angle  (uniform_angle),
		.sample_stall   (sample_stall),
		.sample_valid   (sample_valid),
		.sample         (sample),
		.from_spare     (from_spare)
	);

	`BMNS_ASSERT_NXT(a_spare_consumed, clk, arst_n, req_xfer && sts.spare_valid, !sts.spare_valid)
	`BMNS_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.emit, !sample_valid || !sample_stall)
	`BMNS_ASSERT_NXT(a_busy_after_xfer, clk, arst_n, req_xfer, request_stall)

endmodule
`default_nettype wire
